@@ sv/aesc_pkg.sv @@
package aesc_pkg;

    localparam int EV_W     = 16;
    localparam int COMP_W   = 13;
    localparam int BOUND_W  = 14;
    localparam int RATE_W   = 13;
    localparam int LUM_W    = 32;
    localparam int DT_W     = 24;
    localparam int STEP_W   = RATE_W + DT_W - 16;
    localparam int WIDE_W   = EV_W + 2;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // -log2(0.18) in Q16
    localparam logic signed [22:0] LOG2_INV_MIDGREY_Q16 = 23'sd162132;

    localparam logic [EV_W-1:0]    RST_MANUAL_EV = 16'h0000;
    localparam logic [EV_W-1:0]    RST_REF_EV    = 16'h0000;
    localparam logic [COMP_W-1:0]  RST_COMP_EV   = 13'h0000;
    localparam logic [BOUND_W-1:0] RST_MIN_EV    = 14'h3800;
    localparam logic [BOUND_W-1:0] RST_MAX_EV    = 14'h1400;
    localparam logic [RATE_W-1:0]  RST_RISE_RATE = 13'd768;
    localparam logic [RATE_W-1:0]  RST_FALL_RATE = 13'd768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPOSURE_MODE   = 3'd0,
        REG_MANUAL_EV       = 3'd1,
        REG_REFERENCE_EV    = 3'd2,
        REG_COMPENSATION_EV = 3'd3,
        REG_MIN_EV          = 3'd4,
        REG_MAX_EV          = 3'd5,
        REG_RISE_RATE       = 3'd6,
        REG_FALL_RATE       = 3'd7
    } cfg_reg_t;

    // live configuration, bounds already ordered
    typedef struct packed {
        logic                       auto_mode;
        logic signed [EV_W-1:0]     manual_ev;
        logic signed [EV_W-1:0]     reference_ev;
        logic signed [COMP_W-1:0]   compensation_ev;
        logic signed [BOUND_W-1:0]  lo_ev;
        logic signed [BOUND_W-1:0]  hi_ev;
        logic [RATE_W-1:0]          rise_rate;
        logic [RATE_W-1:0]          fall_rate;
    } cfg_t;

    // classified request handed from front to back
    typedef struct packed {
        logic                       auto_upd;
        logic signed [BOUND_W-1:0]  target;
        logic [STEP_W-1:0]          rise_step;
        logic [STEP_W-1:0]          fall_step;
    } slew_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic signed [WIDE_W-1:0] clamp_wide(
        input logic signed [WIDE_W-1:0] v,
        input logic signed [WIDE_W-1:0] lo,
        input logic signed [WIDE_W-1:0] hi
    );
        logic signed [WIDE_W-1:0] r;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // fractional log2 of a Q30 value in [1,2), squaring method
    function automatic longint unsigned frac_log2(
        input longint unsigned x_in,
        input int              bits
    );
        longint unsigned x;
        longint unsigned r;
        x = x_in;
        r = 0;
        for (int k = 0; k < bits; k++)
        begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= (64'd2 << 30))
            begin
                r = r | 64'd1;
                x = x >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] log_entry(input longint unsigned x_q30);
        return 16'(frac_log2(x_q30, 16));
    endfunction

    // largest Q16 y in [1,2) with log2(y) <= i/n
    function automatic logic [16:0] exp_entry(input int n, input int i);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 64'd65536;
        hi = 64'd131071;
        for (int k = 0; k < 18; k++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi + 64'd1) >> 1;
                if (frac_log2(mid << 14, 24) * longint'(unsigned'(n))
                    <= (longint'(unsigned'(i)) << 24))
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 64'd1;
                end
            end
        end
        return 17'(lo);
    endfunction

endpackage

@@ sv/aesc_in_if.sv @@
interface aesc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] luminance;
    logic        has_measurement;
    logic [23:0] delta_time;

    modport source (output valid, luminance, has_measurement, delta_time, input ready);
    modport sink   (input valid, luminance, has_measurement, delta_time, output ready);
endinterface

@@ sv/aesc_out_if.sv @@
interface aesc_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        exposure_scale;
    logic signed [15:0] current_ev;
    logic               scale_saturated;

    modport source (output valid, exposure_scale, current_ev, scale_saturated, input ready);
    modport sink   (input valid, exposure_scale, current_ev, scale_saturated, output ready);
endinterface

@@ sv/aesc_front.sv @@
module aesc_front #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    aesc_in_if.sink             sample,
    input  aesc_pkg::cfg_t      cfg,
    input  aesc_pkg::q_status_t q_status,
    output logic                push,
    output aesc_pkg::slew_req_t push_req
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int LPROD_W = 31 + $clog2(TABLE_ENTRIES + 1);
    localparam int PROD_W  = aesc_pkg::RATE_W + aesc_pkg::DT_W;
    localparam int WW      = aesc_pkg::WIDE_W;

    logic [15:0] log_tab [TABLE_ENTRIES];

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_log_tab
        localparam longint unsigned X_Q30 =
            ((longint'(TABLE_ENTRIES) + longint'(g)) << 30) / longint'(TABLE_ENTRIES);
        assign log_tab[g] = aesc_pkg::log_entry(X_Q30);
    end

    // stage 1: leading one and slew products
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [31:0]                   s1_lum_reg;
    logic [4:0]                    s1_lead_reg;
    logic                          s1_auto_reg;
    logic [aesc_pkg::STEP_W-1:0]   s1_rise_reg;
    logic [aesc_pkg::STEP_W-1:0]   s1_fall_reg;
    logic                          s1_ready;

    logic [31:0]       lum_eff;
    logic [4:0]        lead;
    logic [PROD_W-1:0] rise_prod;
    logic [PROD_W-1:0] fall_prod;

    // stage 2: log2 lookup and target
    logic                      s2_valid_reg;
    logic                      s2_valid_next;
    aesc_pkg::slew_req_t       s2_req_reg;
    aesc_pkg::slew_req_t       s2_req_next;
    logic                      s2_ready;

    logic [31:0]               norm;
    logic [LPROD_W-1:0]        lprod;
    logic [IDX_W-1:0]          lidx;
    logic signed [6:0]         oct;
    logic signed [22:0]        lv;
    logic signed [22:0]        lv_rnd;
    logic signed [14:0]        rounded;
    logic signed [WW-1:0]      tgt_full;
    logic signed [WW-1:0]      tgt_clamped;

    assign s2_ready      = !s2_valid_reg || !q_status.full;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign sample.ready  = s1_ready;
    assign push          = s2_valid_reg && !q_status.full;
    assign push_req      = s2_req_reg;

    assign s1_valid_next = s1_ready ? sample.valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_comb
    begin
        lum_eff = (sample.luminance == 32'd0) ? 32'd1 : sample.luminance;
        lead    = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (lum_eff[i])
            begin
                lead = 5'(i);
            end
        end
        rise_prod = PROD_W'(sample.delta_time) * PROD_W'(cfg.rise_rate);
        fall_prod = PROD_W'(sample.delta_time) * PROD_W'(cfg.fall_rate);
    end

    always_comb
    begin
        norm     = s1_lum_reg << (5'd31 - s1_lead_reg);
        lprod    = LPROD_W'(norm[30:0]) * LPROD_W'(TABLE_ENTRIES);
        lidx     = lprod[31 +: IDX_W];
        oct      = $signed({2'b00, s1_lead_reg}) - 7'sd16;
        lv       = $signed({oct, 16'h0000}) + $signed({7'b0, log_tab[lidx]})
                   + aesc_pkg::LOG2_INV_MIDGREY_Q16;
        lv_rnd   = lv + 23'sd128;
        rounded  = lv_rnd[22:8];
        tgt_full = $signed({{2{cfg.reference_ev[15]}}, cfg.reference_ev})
                   + $signed({{3{rounded[14]}}, rounded});
        tgt_clamped = aesc_pkg::clamp_wide(tgt_full,
            $signed({{4{cfg.lo_ev[13]}}, cfg.lo_ev}),
            $signed({{4{cfg.hi_ev[13]}}, cfg.hi_ev}));
        s2_req_next.auto_upd  = s1_auto_reg;
        s2_req_next.target    = tgt_clamped[aesc_pkg::BOUND_W-1:0];
        s2_req_next.rise_step = s1_rise_reg;
        s2_req_next.fall_step = s1_fall_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && sample.valid)
        begin
            s1_lum_reg  <= lum_eff;
            s1_lead_reg <= lead;
            s1_auto_reg <= cfg.auto_mode && sample.has_measurement;
            s1_rise_reg <= rise_prod[PROD_W-1:16];
            s1_fall_reg <= fall_prod[PROD_W-1:16];
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_req_reg <= s2_req_next;
        end
    end

endmodule

@@ sv/aesc_queue.sv @@
module aesc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  aesc_pkg::slew_req_t push_req,
    input  logic                pop,
    output aesc_pkg::slew_req_t pop_req,
    output aesc_pkg::q_status_t status
);

    localparam int DEPTH = aesc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aesc_pkg::slew_req_t entries_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_req      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

@@ sv/aesc_back.sv @@
module aesc_back #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  aesc_pkg::cfg_t      cfg,
    input  aesc_pkg::q_status_t q_status,
    input  aesc_pkg::slew_req_t pop_req,
    output logic                pop,
    aesc_out_if.source          result
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int EPROD_W = 8 + $clog2(TABLE_ENTRIES + 1);
    localparam int WW      = aesc_pkg::WIDE_W;
    localparam int SW      = aesc_pkg::STEP_W;

    logic [16:0] exp_tab [TABLE_ENTRIES];

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_exp_tab
        assign exp_tab[g] = aesc_pkg::exp_entry(TABLE_ENTRIES, g);
    end

    // EV state: held_ev_reg is also the payload of the update stage
    logic signed [15:0] held_ev_reg;
    logic signed [15:0] held_ev_next;
    logic               seeded_reg;
    logic               a_valid_reg;
    logic               a_valid_next;
    logic               a_ready;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [31:0]        out_scale_reg;
    logic [31:0]        out_scale_next;
    logic signed [15:0] out_ev_reg;
    logic               out_sat_reg;
    logic               out_sat_next;
    logic               b_ready;

    logic signed [WW-1:0] lo_w;
    logic signed [WW-1:0] hi_w;
    logic signed [WW-1:0] man_w;
    logic signed [WW-1:0] man_clamped;
    logic signed [15:0]   base;
    logic signed [15:0]   tgt;
    logic signed [16:0]   diff;
    logic [SW-1:0]        step;
    logic signed [SW:0]   step_s;
    logic signed [SW:0]   diff_w;
    logic signed [SW:0]   d_w;
    logic signed [WW-1:0] sum_w;
    logic signed [WW-1:0] upd_w;

    logic signed [WW-1:0] e_w;
    logic signed [9:0]    ip;
    logic [9:0]           ip_neg;
    logic [EPROD_W-1:0]   eprod;
    logic [IDX_W-1:0]     eidx;
    logic [16:0]          mant;

    assign b_ready = !out_valid_reg || result.ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign pop     = !q_status.empty && a_ready;

    assign a_valid_next   = a_ready ? pop : a_valid_reg;
    assign out_valid_next = b_ready ? a_valid_reg : out_valid_reg;

    assign result.valid           = out_valid_reg;
    assign result.exposure_scale  = out_scale_reg;
    assign result.current_ev      = out_ev_reg;
    assign result.scale_saturated = out_sat_reg;

    // slew update
    always_comb
    begin
        lo_w  = $signed({{4{cfg.lo_ev[13]}}, cfg.lo_ev});
        hi_w  = $signed({{4{cfg.hi_ev[13]}}, cfg.hi_ev});
        man_w = $signed({{2{cfg.manual_ev[15]}}, cfg.manual_ev});
        man_clamped = aesc_pkg::clamp_wide(man_w, lo_w, hi_w);
        base  = seeded_reg ? held_ev_reg : man_clamped[15:0];
        tgt   = $signed({{2{pop_req.target[13]}}, pop_req.target});
        diff  = $signed({tgt[15], tgt}) - $signed({base[15], base});
        step  = (tgt > base) ? pop_req.rise_step : pop_req.fall_step;
        step_s = $signed({1'b0, step});
        diff_w = $signed({{(SW - 16){diff[16]}}, diff});
        if (diff_w > step_s)
        begin
            d_w = step_s;
        end
        else if (diff_w < -step_s)
        begin
            d_w = -step_s;
        end
        else
        begin
            d_w = diff_w;
        end
        sum_w = $signed({{2{base[15]}}, base}) + $signed({d_w[16], d_w[16:0]});
        upd_w = aesc_pkg::clamp_wide(sum_w, lo_w, hi_w);
        held_ev_next = pop_req.auto_upd ? upd_w[15:0] : cfg.manual_ev;
    end

    // exp2 of (reference - EV + compensation)
    always_comb
    begin
        e_w = $signed({{2{cfg.reference_ev[15]}}, cfg.reference_ev})
              - $signed({{2{held_ev_reg[15]}}, held_ev_reg})
              + $signed({{5{cfg.compensation_ev[12]}}, cfg.compensation_ev});
        ip     = e_w[17:8];
        ip_neg = 10'(-ip);
        eprod  = EPROD_W'(e_w[7:0]) * EPROD_W'(TABLE_ENTRIES);
        eidx   = eprod[8 +: IDX_W];
        mant   = exp_tab[eidx];
        priority if (ip >= 10'sd16)
        begin
            out_scale_next = '1;
        end
        else if (ip >= 10'sd0)
        begin
            out_scale_next = 32'(mant) << ip[3:0];
        end
        else if (ip <= -10'sd32)
        begin
            out_scale_next = '0;
        end
        else
        begin
            out_scale_next = 32'(mant) >> ip_neg[4:0];
        end
        out_sat_next = (ip >= 10'sd16) || (out_scale_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_ev_reg   <= '0;
            seeded_reg    <= 1'b0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                held_ev_reg <= held_ev_next;
                seeded_reg  <= 1'b1;
            end
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            out_scale_reg <= out_scale_next;
            out_ev_reg    <= held_ev_reg;
            out_sat_reg   <= out_sat_next;
        end
    end

endmodule

@@ sv/auto_exposure_slew_control.sv @@
// Auto-exposure slew control: luminance in, EV and exposure scale out.
// From an accepted request to its result: two front stages, one queue slot,
// the EV update register, the exp2 output register. The EV recurrence closes
// through held_ev_reg. Throughput: one request per cycle while not stalled.
// Reset: rst_n asynchronous, active low; EV 0, not seeded, pipeline empty,
// configuration registers to their documented defaults.
module auto_exposure_slew_control #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    aesc_in_if.sink     sample,
    aesc_out_if.source  result
);

    // configuration registers
    logic                                exposure_mode_reg;
    logic [aesc_pkg::EV_W-1:0]           manual_ev_reg;
    logic [aesc_pkg::EV_W-1:0]           reference_ev_reg;
    logic [aesc_pkg::COMP_W-1:0]         compensation_ev_reg;
    logic [aesc_pkg::BOUND_W-1:0]        min_ev_reg;
    logic [aesc_pkg::BOUND_W-1:0]        max_ev_reg;
    logic [aesc_pkg::RATE_W-1:0]         rise_rate_reg;
    logic [aesc_pkg::RATE_W-1:0]         fall_rate_reg;

    aesc_pkg::cfg_t      cfg;
    aesc_pkg::q_status_t q_status;
    aesc_pkg::slew_req_t q_push_req;
    aesc_pkg::slew_req_t q_pop_req;
    logic                q_push;
    logic                q_pop;
    logic                min_above_max;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exposure_mode_reg   <= 1'b0;
            manual_ev_reg       <= aesc_pkg::RST_MANUAL_EV;
            reference_ev_reg    <= aesc_pkg::RST_REF_EV;
            compensation_ev_reg <= aesc_pkg::RST_COMP_EV;
            min_ev_reg          <= aesc_pkg::RST_MIN_EV;
            max_ev_reg          <= aesc_pkg::RST_MAX_EV;
            rise_rate_reg       <= aesc_pkg::RST_RISE_RATE;
            fall_rate_reg       <= aesc_pkg::RST_FALL_RATE;
        end
        else if (cfg_wr_en)
        begin
            unique case (aesc_pkg::cfg_reg_t'(cfg_index))
                aesc_pkg::REG_EXPOSURE_MODE:   exposure_mode_reg   <= cfg_data[0];
                aesc_pkg::REG_MANUAL_EV:       manual_ev_reg       <= cfg_data;
                aesc_pkg::REG_REFERENCE_EV:    reference_ev_reg    <= cfg_data;
                aesc_pkg::REG_COMPENSATION_EV:
                    compensation_ev_reg <= cfg_data[aesc_pkg::COMP_W-1:0];
                aesc_pkg::REG_MIN_EV:  min_ev_reg <= cfg_data[aesc_pkg::BOUND_W-1:0];
                aesc_pkg::REG_MAX_EV:  max_ev_reg <= cfg_data[aesc_pkg::BOUND_W-1:0];
                aesc_pkg::REG_RISE_RATE:
                    rise_rate_reg <= cfg_data[aesc_pkg::RATE_W-1:0];
                aesc_pkg::REG_FALL_RATE:
                    fall_rate_reg <= cfg_data[aesc_pkg::RATE_W-1:0];
            endcase
        end
    end

    // bounds may be written in either order; the smaller is the low bound
    assign min_above_max = $signed(min_ev_reg) > $signed(max_ev_reg);

    always_comb
    begin
        cfg.auto_mode       = exposure_mode_reg;
        cfg.manual_ev       = manual_ev_reg;
        cfg.reference_ev    = reference_ev_reg;
        cfg.compensation_ev = compensation_ev_reg;
        cfg.lo_ev           = min_above_max ? max_ev_reg : min_ev_reg;
        cfg.hi_ev           = min_above_max ? min_ev_reg : max_ev_reg;
        cfg.rise_rate       = rise_rate_reg;
        cfg.fall_rate       = fall_rate_reg;
    end

    // front: leading-one search and slew limits, then log2 lookup and target
    aesc_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample),
        .cfg      (cfg),
        .q_status (q_status),
        .push     (q_push),
        .push_req (q_push_req)
    );

    // short queue so front and back stall independently
    aesc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_req (q_push_req),
        .pop      (q_pop),
        .pop_req  (q_pop_req),
        .status   (q_status)
    );

    // back: seeding, slew-limited EV update, exp2 scale into output register
    aesc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_status (q_status),
        .pop_req  (q_pop_req),
        .pop      (q_pop),
        .result   (result)
    );

    // front never writes a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("request pushed into full queue");

    // back never reads an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("request popped from empty queue");

    // a push always leaves something queued
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> !q_status.empty)
        else $error("pushed request lost");

    // saturation flag matches the scale limits
    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.scale_saturated ==
            ((result.exposure_scale == 32'h0000_0000) ||
             (result.exposure_scale == 32'hFFFF_FFFF))))
        else $error("saturation flag inconsistent with scale");

endmodule
